[hw/rtl/fpc_pkg.sv]
// ----------------------------------------------------------------------------
// Frustum plane culling package
// Shared constants, request codes and the command bundle that the controller
// sends to the datapath.
// ----------------------------------------------------------------------------
package fpc_pkg;

   localparam int NUM_PLANES  = 5;
   localparam int PLANE_SEL_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_SPHERE = 2'd1;
   localparam logic [1:0] KIND_BOX    = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   typedef struct packed {
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic signed [31:0] plane_offset;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic [30:0]        size_x;
      logic [30:0]        size_y;
      logic [30:0]        size_z;
      logic [2:0]         plane_index;
      logic               is_box;
   } req_payload_type;

   typedef struct packed {
      logic                   load;
      logic                   capture;
      logic                   step;
      logic [PLANE_SEL_W-1:0] plane_sel;
      logic                   acc_en;
      logic                   push;
   } cmd_type;

endpackage

[hw/rtl/fpc_channels.sv]
// ----------------------------------------------------------------------------
// Frustum plane culling channels
// Valid/ready interfaces for the request channel and the response channel.
// ----------------------------------------------------------------------------
interface fpc_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [2:0]         plane_index;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [15:0] normal_z;
   logic signed [31:0] plane_offset;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   logic [30:0]        size_x;
   logic [30:0]        size_y;
   logic [30:0]        size_z;

   modport source (output valid, kind, plane_index, normal_x, normal_y, normal_z,
                   plane_offset, point_x, point_y, point_z, size_x, size_y, size_z,
                   input ready);
   modport sink (input valid, kind, plane_index, normal_x, normal_y, normal_z,
                 plane_offset, point_x, point_y, point_z, size_x, size_y, size_z,
                 output ready);
endinterface

interface fpc_rsp_if;
   logic valid;
   logic ready;
   logic visible;

   modport source (output valid, visible, input ready);
   modport sink (input valid, visible, output ready);
endinterface

[hw/rtl/fpc_ctrl.sv]
// ----------------------------------------------------------------------------
// Frustum plane culling controller
// Accepts requests, walks the plane table once per query and hands the
// verdict to the response register.
// ----------------------------------------------------------------------------
module fpc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_kind,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fpc_pkg::cmd_type  cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_RUN   = 2'd1;
   localparam logic [1:0] S_FINAL = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   localparam logic [fpc_pkg::PLANE_SEL_W-1:0] LAST_PLANE =
      fpc_pkg::PLANE_SEL_W'(fpc_pkg::NUM_PLANES - 1);

   logic [1:0]                       state_ff, state_in;
   logic [fpc_pkg::PLANE_SEL_W-1:0]  cnt_ff, cnt_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             accept;
   logic                             slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd           = '0;
      cmd.plane_sel = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  fpc_pkg::KIND_LOAD: begin
                     cmd.load = 1'b1;
                  end
                  fpc_pkg::KIND_SPHERE, fpc_pkg::KIND_BOX: begin
                     cmd.capture = 1'b1;
                     cnt_in      = '0;
                     state_in    = S_RUN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RUN: begin
            cmd.step   = 1'b1;
            cmd.acc_en = (cnt_ff != '0);
            if (cnt_ff == LAST_PLANE) begin
               state_in = S_FINAL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_FINAL: begin
            cmd.acc_en = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.push     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hw/rtl/fpc_datapath.sv]
// ----------------------------------------------------------------------------
// Frustum plane culling datapath
// Plane table, captured query operands, a product stage of three multipliers
// and a sum-and-sign stage that folds each plane into the verdict.
// ----------------------------------------------------------------------------
module fpc_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  fpc_pkg::req_payload_type req,
   input  fpc_pkg::cmd_type         cmd,
   output logic                     rsp_visible
);

   logic signed [15:0] normal_x_ff [fpc_pkg::NUM_PLANES];
   logic signed [15:0] normal_y_ff [fpc_pkg::NUM_PLANES];
   logic signed [15:0] normal_z_ff [fpc_pkg::NUM_PLANES];
   logic signed [31:0] offset_ff   [fpc_pkg::NUM_PLANES];

   logic signed [31:0] point_x_ff, point_y_ff, point_z_ff;
   logic [30:0]        size_x_ff, size_y_ff, size_z_ff;
   logic               is_box_ff;

   logic signed [48:0] prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [48:0] prod_x_in, prod_y_in, prod_z_in;
   logic signed [33:0] bias_ff, bias_in;
   logic               vis_ff, vis_in;
   logic               rsp_visible_ff;

   logic signed [15:0] n_x, n_y, n_z;
   logic signed [31:0] n_off;
   logic signed [32:0] v_x, v_y, v_z;
   logic signed [33:0] rad_ext, off_ext;
   logic signed [52:0] lhs;
   logic               load_hit;

   assign load_hit = cmd.load &&
                     (32'(req.plane_index) < 32'(fpc_pkg::NUM_PLANES));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fpc_pkg::NUM_PLANES; i++) begin
            normal_x_ff[i] <= '0;
            normal_y_ff[i] <= '0;
            normal_z_ff[i] <= '0;
            offset_ff[i]   <= '0;
         end
      end else if (load_hit) begin
         normal_x_ff[req.plane_index[fpc_pkg::PLANE_SEL_W-1:0]] <= req.normal_x;
         normal_y_ff[req.plane_index[fpc_pkg::PLANE_SEL_W-1:0]] <= req.normal_y;
         normal_z_ff[req.plane_index[fpc_pkg::PLANE_SEL_W-1:0]] <= req.normal_z;
         offset_ff[req.plane_index[fpc_pkg::PLANE_SEL_W-1:0]]   <= req.plane_offset;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         point_x_ff <= req.point_x;
         point_y_ff <= req.point_y;
         point_z_ff <= req.point_z;
         size_x_ff  <= req.size_x;
         size_y_ff  <= req.size_y;
         size_z_ff  <= req.size_z;
         is_box_ff  <= req.is_box;
      end
   end

   // For a box, the extent is added along every axis whose normal component
   // is non-negative, which gives the vertex farthest along the normal.
   always_comb begin
      n_x     = normal_x_ff[cmd.plane_sel];
      n_y     = normal_y_ff[cmd.plane_sel];
      n_z     = normal_z_ff[cmd.plane_sel];
      n_off   = offset_ff[cmd.plane_sel];
      v_x     = 33'(point_x_ff);
      v_y     = 33'(point_y_ff);
      v_z     = 33'(point_z_ff);
      if (is_box_ff && !n_x[15]) begin
         v_x = 33'(point_x_ff) + $signed({2'b00, size_x_ff});
      end
      if (is_box_ff && !n_y[15]) begin
         v_y = 33'(point_y_ff) + $signed({2'b00, size_y_ff});
      end
      if (is_box_ff && !n_z[15]) begin
         v_z = 33'(point_z_ff) + $signed({2'b00, size_z_ff});
      end
      prod_x_in = 49'(n_x) * 49'(v_x);
      prod_y_in = 49'(n_y) * 49'(v_y);
      prod_z_in = 49'(n_z) * 49'(v_z);
      rad_ext   = $signed({3'b000, size_x_ff});
      off_ext   = 34'(n_off);
      bias_in   = is_box_ff ? -off_ext : rad_ext - off_ext;
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
         bias_ff   <= bias_in;
      end
   end

   always_comb begin
      lhs = 53'(prod_x_ff) + 53'(prod_y_ff) + 53'(prod_z_ff) + (53'(bias_ff) <<< 14);
      priority if (cmd.capture) begin
         vis_in = 1'b1;
      end else if (cmd.acc_en) begin
         vis_in = vis_ff && !lhs[52];
      end else begin
         vis_in = vis_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vis_ff <= 1'b1;
      end else begin
         vis_ff <= vis_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_visible_ff <= vis_ff;
      end
   end

   assign rsp_visible = rsp_visible_ff;

endmodule

[hw/rtl/frustum_plane_culling.sv]
// ----------------------------------------------------------------------------
// Frustum plane culling
// A query is captured when accepted; the single shared dot-product unit
// visits the five planes in turn and the verdict waits until the response
// register is free. A load is absorbed in the cycle it is accepted and gives
// no response. Queries are taken one at a time; loads go back to back.
// Reset clears the plane table to zero and empties the response register.
// ----------------------------------------------------------------------------
module frustum_plane_culling (
   input  logic      clock,
   input  logic      reset,
   fpc_req_if.sink   req_ch,
   fpc_rsp_if.source rsp_ch
);

   fpc_pkg::cmd_type         cmd;
   fpc_pkg::req_payload_type req_payload;

   always_comb begin
      req_payload.normal_x     = req_ch.normal_x;
      req_payload.normal_y     = req_ch.normal_y;
      req_payload.normal_z     = req_ch.normal_z;
      req_payload.plane_offset = req_ch.plane_offset;
      req_payload.point_x      = req_ch.point_x;
      req_payload.point_y      = req_ch.point_y;
      req_payload.point_z      = req_ch.point_z;
      req_payload.size_x       = req_ch.size_x;
      req_payload.size_y       = req_ch.size_y;
      req_payload.size_z       = req_ch.size_z;
      req_payload.plane_index  = req_ch.plane_index;
      req_payload.is_box       = (req_ch.kind == fpc_pkg::KIND_BOX);
   end

   fpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_kind  (req_ch.kind),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   fpc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req         (req_payload),
      .cmd         (cmd),
      .rsp_visible (rsp_ch.visible)
   );

   a_push_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("Response register overwritten while still full.");

   a_walk_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (cmd.step && cmd.plane_sel == '0))
      else $error("Plane walk did not start at the first plane.");

   a_last_plane_folded: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && cmd.plane_sel == fpc_pkg::PLANE_SEL_W'(fpc_pkg::NUM_PLANES - 1))
      |=> (cmd.acc_en && !cmd.step))
      else $error("Last plane was not folded into the verdict.");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (cmd.step || cmd.acc_en) |-> !req_ch.ready)
      else $error("Request accepted while a query is in progress.");

endmodule
